// File: rtl/core/best_fit_free_list_allocator_unit_assert.svh
// Assertion macros for the best-fit free-list allocator.
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");
`else
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/bfa_pkg.sv
// Shared types and constants of the best-fit free-list allocator.
`default_nettype none
package bfa_pkg;
   localparam int DEF_MAX_FREE_SEGMENTS = 16;
   localparam int DEF_MAX_LIVE_ALLOCS   = 16;
   localparam int DEF_HEADER_BYTES      = 16;

   localparam int ADDR_W    = 32;
   localparam int ALIGN_W   = 3;
   localparam int STATUS_W  = 3;
   localparam int LIVE_W    = 5;
   localparam int ADJ_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd0;
   localparam logic [ADDR_W-1:0] POOL_SIZE_RESET = 32'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE = 1'b1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_FIT     = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_UNKNOWN    = 3'd3,
      ST_BAD        = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_REC_SCAN,
      DP_SEG_SCAN,
      DP_COMMIT,
      DP_SHIFT_DOWN,
      DP_FREE_PREP,
      DP_FREE_SCAN,
      DP_FREE_MERGE,
      DP_SHIFT_UP,
      DP_SET_STATUS,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type st;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic rec_end;
      logic rec_hit;
      logic seg_end;
      logic exact;
      logic found;
      logic rest_small;
      logic seg_below;
      logic mp;
      logic mn;
      logic seg_full;
      logic up_more;
      logic rsp_busy;
   } dp_stat_type;
endpackage
`default_nettype wire

// File: rtl/core/bfa_req_if.sv
// Request channel interface of the allocator.
`default_nettype none
interface bfa_req_if;
   import bfa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [ADDR_W-1:0]    req_size;
   logic [ALIGN_W-1:0]   align_log2;
   logic [ADDR_W-1:0]    free_address;
   modport source (output valid, func, req_size, align_log2, free_address, input ready);
   modport sink (input valid, func, req_size, align_log2, free_address, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bfa_rsp_if.sv
// Response channel interface of the allocator.
`default_nettype none
interface bfa_rsp_if;
   import bfa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    block_address;
   logic [STATUS_W-1:0]  status;
   logic [ADDR_W-1:0]    used_bytes;
   logic [LIVE_W-1:0]    live_count;
   modport source (output valid, block_address, status, used_bytes, live_count, input ready);
   modport sink (input valid, block_address, status, used_bytes, live_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/best_fit_free_list_allocator_unit.sv
// Top level of the best-fit free-list allocator with coalescing.
//
//   Channel   Direction   Contents
//   req_chan  in          func, req_size, align_log2, free_address
//   rsp_chan  out         block_address, status, used_bytes, live_count
//   csr       in          csr_write, csr_index, csr_data (pool_base, pool_size)
//
// One request is in work at a time. How long an allocate or a free takes is set by the
// record scan, the segment scan and the one-entry-per-cycle table shift, all through
// single-port table reads.
// Reset is synchronous and leaves one free segment covering the default pool.
// A result waits in the output register while rsp_chan is stalled; the next request
// is taken meanwhile and holds in its last step until that register empties.
`default_nettype none
`include "best_fit_free_list_allocator_unit_assert.svh"
module best_fit_free_list_allocator_unit #(
   parameter int MAX_FREE_SEGMENTS = bfa_pkg::DEF_MAX_FREE_SEGMENTS,
   parameter int MAX_LIVE_ALLOCS   = bfa_pkg::DEF_MAX_LIVE_ALLOCS,
   parameter int HEADER_BYTES      = bfa_pkg::DEF_HEADER_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   bfa_req_if.sink                       req_chan,
   bfa_rsp_if.source                     rsp_chan,
   input  logic                          csr_write,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]    csr_data
);
   import bfa_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bfa_datapath #(
      .MAX_FREE_SEGMENTS (MAX_FREE_SEGMENTS),
      .MAX_LIVE_ALLOCS   (MAX_LIVE_ALLOCS),
      .HEADER_BYTES      (HEADER_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .req_func          (req_chan.func),
      .req_size          (req_chan.req_size),
      .req_align_log2    (req_chan.align_log2),
      .req_free_address  (req_chan.free_address),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_block_address (rsp_chan.block_address),
      .rsp_status        (rsp_chan.status),
      .rsp_used_bytes    (rsp_chan.used_bytes),
      .rsp_live_count    (rsp_chan.live_count)
   );

   `BFA_ASSERT_NXT(a_leave_idle, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `BFA_ASSERT_IMP(a_err_zero_addr, clock, reset, rsp_chan.valid && (rsp_chan.status != ST_OK), rsp_chan.block_address == '0)
   `BFA_ASSERT_IMP(a_result_slot_free, clock, reset, dp_cmd.op == DP_RESULT, !dp_stat.rsp_busy)
endmodule
`default_nettype wire

// File: rtl/core/bfa_datapath.sv
// Datapath of the allocator: segment and record tables, scan registers and counters.
`default_nettype none
module bfa_datapath #(
   parameter int MAX_FREE_SEGMENTS = bfa_pkg::DEF_MAX_FREE_SEGMENTS,
   parameter int MAX_LIVE_ALLOCS   = bfa_pkg::DEF_MAX_LIVE_ALLOCS,
   parameter int HEADER_BYTES      = bfa_pkg::DEF_HEADER_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bfa_pkg::dp_cmd_type               cmd,
   output bfa_pkg::dp_stat_type              stat,
   input  logic                              req_func,
   input  logic [bfa_pkg::ADDR_W-1:0]        req_size,
   input  logic [bfa_pkg::ALIGN_W-1:0]       req_align_log2,
   input  logic [bfa_pkg::ADDR_W-1:0]        req_free_address,
   input  logic                              csr_write,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]        csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [bfa_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [bfa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bfa_pkg::ADDR_W-1:0]        rsp_used_bytes,
   output logic [bfa_pkg::LIVE_W-1:0]        rsp_live_count
);
   import bfa_pkg::*;

   localparam int NS   = MAX_FREE_SEGMENTS;
   localparam int NL   = MAX_LIVE_ALLOCS;
   localparam int SAW  = $clog2(NS);
   localparam int RAW  = $clog2(NL);
   localparam int CW   = $clog2(NS + 1);
   localparam int MAXN = (NS > NL) ? NS : NL;
   localparam int IW   = $clog2(MAXN + 1);

   logic [ADDR_W-1:0] seg_start_mem [NS];
   logic [ADDR_W-1:0] seg_len_mem [NS];
   logic [ADDR_W-1:0] rec_addr_mem [NL];
   logic [ADDR_W-1:0] rec_total_mem [NL];
   logic [ADJ_W-1:0]  rec_adj_mem [NL];

   logic [ADDR_W-1:0] rd_start_ff, rd_len_ff;
   logic [ADDR_W-1:0] rd_raddr_ff, rd_rtotal_ff;
   logic [ADJ_W-1:0]  rd_radj_ff;

   logic [ADDR_W-1:0] base_ff, base_in, size_ff, size_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [NL-1:0]     valid_ff, valid_in;
   logic [ADDR_W-1:0] used_ff, used_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   logic [IW-1:0]     idx_ff, idx_in, kpos_ff, kpos_in;
   logic              found_ff, found_in, have_prev_ff, have_prev_in, ins_ff, ins_in;
   logic              func_ff, func_in;
   logic [ADDR_W-1:0] size_req_ff, size_req_in, faddr_ff, faddr_in;
   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [RAW-1:0]    slot_ff, slot_in;
   logic [ADDR_W-1:0] hit_total_ff, hit_total_in;
   logic [ADJ_W-1:0]  hit_adj_ff, hit_adj_in;
   logic [SAW-1:0]    best_idx_ff, best_idx_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in, best_len_ff, best_len_in;
   logic [ADDR_W-1:0] best_total_ff, best_total_in;
   logic [ADJ_W-1:0]  best_adj_ff, best_adj_in;
   logic [ADDR_W-1:0] bstart_ff, bstart_in, bend_ff, bend_in;
   logic [ADDR_W-1:0] prev_start_ff, prev_start_in, prev_len_ff, prev_len_in;
   logic [ADDR_W-1:0] prev_end_ff, prev_end_in;
   status_type        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in, addr_ff, addr_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [ADDR_W-1:0] rsp_used_ff, rsp_used_in;
   logic [LIVE_W-1:0] rsp_live_ff, rsp_live_in;

   logic              seg_we, rec_we;
   logic [SAW-1:0]    seg_waddr, seg_raddr;
   logic [RAW-1:0]    rec_raddr;
   logic [ADDR_W-1:0] seg_wstart, seg_wlen;
   logic [IW-1:0]     idx_inc, idx_dec;
   logic [RAW-1:0]    ri;
   logic [ADJ_W-1:0]  amask, adj0, need, adj;
   logic [ADDR_W:0]   total33, len33;
   logic [ADDR_W-1:0] rest, grant;
   logic              seg_end, rec_end, rec_hit, exact, better, rest_small;
   logic              seg_below, mp, mn, seg_full;

   assign idx_inc = idx_ff + IW'(1);
   assign idx_dec = idx_ff - IW'(1);
   assign ri      = idx_ff[RAW-1:0];

   assign amask = (ADJ_W'(1) << align_ff) - ADJ_W'(1);
   assign adj0  = (~rd_start_ff[ADJ_W-1:0] + ADJ_W'(1)) & amask;
   assign need  = ADJ_W'(HEADER_BYTES) - adj0;
   always_comb begin
      if (adj0 < ADJ_W'(HEADER_BYTES)) begin
         adj = adj0 + (((need + amask) >> align_ff) << align_ff);
      end else begin
         adj = adj0;
      end
   end

   assign total33    = {1'b0, size_req_ff} + (ADDR_W + 1)'(adj);
   assign len33      = {1'b0, rd_len_ff};
   assign seg_end    = idx_ff >= IW'(count_ff);
   assign rec_end    = idx_ff == IW'(NL);
   assign rec_hit    = !rec_end && ((func_ff == FUNC_FREE) ?
                       (valid_ff[ri] && rd_raddr_ff == faddr_ff) : !valid_ff[ri]);
   assign exact      = !seg_end && len33 == total33;
   assign better     = !seg_end && len33 > total33 &&
                       (!found_ff || rd_len_ff < best_len_ff);
   assign rest       = best_len_ff - best_total_ff;
   assign rest_small = rest <= ADDR_W'(HEADER_BYTES);
   assign grant      = rest_small ? best_len_ff : best_total_ff;
   assign seg_below  = !seg_end && rd_start_ff < bend_ff;
   assign mp         = have_prev_ff && prev_end_ff == bstart_ff;
   assign mn         = !seg_end && rd_start_ff == bend_ff;
   assign seg_full   = count_ff >= CW'(NS);

   always_comb begin
      base_in       = base_ff;
      size_in       = size_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      kpos_in       = kpos_ff;
      found_in      = found_ff;
      have_prev_in  = have_prev_ff;
      ins_in        = ins_ff;
      func_in       = func_ff;
      size_req_in   = size_req_ff;
      faddr_in      = faddr_ff;
      align_in      = align_ff;
      slot_in       = slot_ff;
      hit_total_in  = hit_total_ff;
      hit_adj_in    = hit_adj_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      best_total_in = best_total_ff;
      best_adj_in   = best_adj_ff;
      bstart_in     = bstart_ff;
      bend_in       = bend_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      prev_end_in   = prev_end_ff;
      st_in         = st_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_live_in   = rsp_live_ff;
      seg_we        = 1'b0;
      seg_waddr     = idx_ff[SAW-1:0];
      seg_wstart    = rd_start_ff;
      seg_wlen      = rd_len_ff;
      rec_we        = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            func_in      = req_func;
            size_req_in  = req_size;
            align_in     = req_align_log2;
            faddr_in     = req_free_address;
            idx_in       = '0;
            found_in     = 1'b0;
            have_prev_in = 1'b0;
         end
         DP_REC_SCAN: begin
            if (rec_hit) begin
               slot_in      = ri;
               hit_total_in = rd_rtotal_ff;
               hit_adj_in   = rd_radj_ff;
               idx_in       = '0;
            end else begin
               idx_in = idx_inc;
            end
         end
         DP_SEG_SCAN: begin
            if (!seg_end) begin
               if (exact || better) begin
                  best_idx_in   = idx_ff[SAW-1:0];
                  best_start_in = rd_start_ff;
                  best_len_in   = rd_len_ff;
                  best_total_in = total33[ADDR_W-1:0];
                  best_adj_in   = adj;
                  found_in      = 1'b1;
               end
               idx_in = idx_inc;
            end
         end
         DP_COMMIT: begin
            rec_we           = 1'b1;
            valid_in[slot_ff] = 1'b1;
            used_in          = used_ff + grant;
            live_in          = live_ff + LIVE_W'(1);
            st_in            = ST_OK;
            addr_in          = best_start_ff + ADDR_W'(best_adj_ff);
            if (rest_small) begin
               idx_in = IW'(best_idx_ff) + IW'(1);
            end else begin
               seg_we     = 1'b1;
               seg_waddr  = best_idx_ff;
               seg_wstart = best_start_ff + best_total_ff;
               seg_wlen   = rest;
            end
         end
         DP_SHIFT_DOWN: begin
            if (!seg_end) begin
               seg_we    = 1'b1;
               seg_waddr = idx_dec[SAW-1:0];
               idx_in    = idx_inc;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         DP_FREE_PREP: begin
            bstart_in    = faddr_ff - ADDR_W'(hit_adj_ff);
            bend_in      = faddr_ff - ADDR_W'(hit_adj_ff) + hit_total_ff;
            idx_in       = '0;
            have_prev_in = 1'b0;
         end
         DP_FREE_SCAN: begin
            if (seg_below) begin
               prev_start_in = rd_start_ff;
               prev_len_in   = rd_len_ff;
               prev_end_in   = rd_start_ff + rd_len_ff;
               have_prev_in  = 1'b1;
               idx_in        = idx_inc;
            end
         end
         DP_FREE_MERGE: begin
            ins_in = 1'b0;
            if (mp || mn || !seg_full) begin
               valid_in[slot_ff] = 1'b0;
               used_in           = used_ff - hit_total_ff;
               live_in           = live_ff - LIVE_W'(1);
               st_in             = ST_OK;
            end
            if (mp && mn) begin
               seg_we     = 1'b1;
               seg_waddr  = idx_dec[SAW-1:0];
               seg_wstart = prev_start_ff;
               seg_wlen   = prev_len_ff + hit_total_ff + rd_len_ff;
               idx_in     = idx_inc;
            end else if (mp) begin
               seg_we     = 1'b1;
               seg_waddr  = idx_dec[SAW-1:0];
               seg_wstart = prev_start_ff;
               seg_wlen   = prev_len_ff + hit_total_ff;
            end else if (mn) begin
               seg_we     = 1'b1;
               seg_wstart = bstart_ff;
               seg_wlen   = rd_len_ff + hit_total_ff;
            end else if (seg_full) begin
               st_in = ST_TABLE_FULL;
            end else if (seg_end) begin
               seg_we     = 1'b1;
               seg_wstart = bstart_ff;
               seg_wlen   = hit_total_ff;
               count_in   = count_ff + CW'(1);
            end else begin
               kpos_in = idx_ff;
               idx_in  = IW'(count_ff) - IW'(1);
            end
         end
         DP_SHIFT_UP: begin
            seg_we = 1'b1;
            if (!ins_ff) begin
               seg_waddr = idx_inc[SAW-1:0];
               if (idx_ff == kpos_ff) begin
                  ins_in = 1'b1;
               end else begin
                  idx_in = idx_dec;
               end
            end else begin
               seg_waddr  = kpos_ff[SAW-1:0];
               seg_wstart = bstart_ff;
               seg_wlen   = hit_total_ff;
               count_in   = count_ff + CW'(1);
            end
         end
         DP_SET_STATUS: begin
            st_in = cmd.st;
         end
         DP_RESULT: begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = (st_ff == ST_OK && func_ff == FUNC_ALLOC) ? addr_ff : '0;
            rsp_st_in    = st_ff;
            rsp_used_in  = used_ff;
            rsp_live_in  = live_ff;
         end
         default: begin
         end
      endcase
      if (csr_write) begin
         if (csr_index == CSR_POOL_BASE) begin
            base_in = csr_data;
         end else begin
            size_in = csr_data;
         end
         seg_we     = 1'b1;
         seg_waddr  = '0;
         seg_wstart = base_in;
         seg_wlen   = size_in;
         count_in   = (size_in != '0) ? CW'(1) : '0;
         valid_in   = '0;
         used_in    = '0;
         live_in    = '0;
      end
   end

   assign seg_raddr = idx_in[SAW-1:0];
   assign rec_raddr = idx_in[RAW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_mem[0] <= POOL_BASE_RESET;
         seg_len_mem[0]   <= POOL_SIZE_RESET;
      end else if (seg_we) begin
         seg_start_mem[seg_waddr] <= seg_wstart;
         seg_len_mem[seg_waddr]   <= seg_wlen;
      end
      if (seg_we && seg_waddr == seg_raddr) begin
         rd_start_ff <= seg_wstart;
         rd_len_ff   <= seg_wlen;
      end else begin
         rd_start_ff <= seg_start_mem[seg_raddr];
         rd_len_ff   <= seg_len_mem[seg_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_addr_mem[slot_ff]  <= addr_in;
         rec_total_mem[slot_ff] <= grant;
         rec_adj_mem[slot_ff]   <= best_adj_ff;
      end
      if (rec_we && slot_ff == rec_raddr) begin
         rd_raddr_ff  <= addr_in;
         rd_rtotal_ff <= grant;
         rd_radj_ff   <= best_adj_ff;
      end else begin
         rd_raddr_ff  <= rec_addr_mem[rec_raddr];
         rd_rtotal_ff <= rec_total_mem[rec_raddr];
         rd_radj_ff   <= rec_adj_mem[rec_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= POOL_BASE_RESET;
         size_ff      <= POOL_SIZE_RESET;
         count_ff     <= CW'(1);
         valid_ff     <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         idx_ff       <= '0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         idx_ff       <= idx_in;
         ins_ff       <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kpos_ff       <= kpos_in;
      found_ff      <= found_in;
      have_prev_ff  <= have_prev_in;
      func_ff       <= func_in;
      size_req_ff   <= size_req_in;
      faddr_ff      <= faddr_in;
      align_ff      <= align_in;
      slot_ff       <= slot_in;
      hit_total_ff  <= hit_total_in;
      hit_adj_ff    <= hit_adj_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      best_total_ff <= best_total_in;
      best_adj_ff   <= best_adj_in;
      bstart_ff     <= bstart_in;
      bend_ff       <= bend_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      prev_end_ff   <= prev_end_in;
      st_ff         <= st_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign stat.is_free    = func_ff == FUNC_FREE;
   assign stat.size_zero  = size_req_ff == '0;
   assign stat.rec_end    = rec_end;
   assign stat.rec_hit    = rec_hit;
   assign stat.seg_end    = seg_end;
   assign stat.exact      = exact;
   assign stat.found      = found_ff;
   assign stat.rest_small = rest_small;
   assign stat.seg_below  = seg_below;
   assign stat.mp         = mp;
   assign stat.mn         = mn;
   assign stat.seg_full   = seg_full;
   assign stat.up_more    = !ins_ff;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_used_bytes    = rsp_used_ff;
   assign rsp_live_count    = rsp_live_ff;
endmodule
`default_nettype wire

// File: rtl/core/bfa_controller.sv
// Controller state machine of the allocator.
`default_nettype none
module bfa_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bfa_pkg::dp_stat_type  stat,
   output bfa_pkg::dp_cmd_type   cmd
);
   import bfa_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_REC_SCAN   = 10'b0000000010,
      S_SEG_SCAN   = 10'b0000000100,
      S_COMMIT     = 10'b0000001000,
      S_SHIFT_DOWN = 10'b0000010000,
      S_FREE_PREP  = 10'b0000100000,
      S_FREE_SCAN  = 10'b0001000000,
      S_FREE_MERGE = 10'b0010000000,
      S_SHIFT_UP   = 10'b0100000000,
      S_RESULT     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      cmd.st   = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_REC_SCAN;
            end
         end
         S_REC_SCAN: begin
            if (!stat.is_free && stat.size_zero) begin
               cmd.op   = DP_SET_STATUS;
               cmd.st   = ST_BAD;
               state_in = S_RESULT;
            end else if (stat.rec_end) begin
               cmd.op   = DP_SET_STATUS;
               cmd.st   = stat.is_free ? ST_UNKNOWN : ST_TABLE_FULL;
               state_in = S_RESULT;
            end else begin
               cmd.op = DP_REC_SCAN;
               if (stat.rec_hit) begin
                  state_in = stat.is_free ? S_FREE_PREP : S_SEG_SCAN;
               end
            end
         end
         S_SEG_SCAN: begin
            if (stat.seg_end && !stat.found) begin
               cmd.op   = DP_SET_STATUS;
               cmd.st   = ST_NO_FIT;
               state_in = S_RESULT;
            end else begin
               cmd.op = DP_SEG_SCAN;
               if (stat.seg_end || stat.exact) begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            cmd.op   = DP_COMMIT;
            state_in = stat.rest_small ? S_SHIFT_DOWN : S_RESULT;
         end
         S_SHIFT_DOWN: begin
            cmd.op = DP_SHIFT_DOWN;
            if (stat.seg_end) begin
               state_in = S_RESULT;
            end
         end
         S_FREE_PREP: begin
            cmd.op   = DP_FREE_PREP;
            state_in = S_FREE_SCAN;
         end
         S_FREE_SCAN: begin
            cmd.op = DP_FREE_SCAN;
            if (!stat.seg_below) begin
               state_in = S_FREE_MERGE;
            end
         end
         S_FREE_MERGE: begin
            cmd.op = DP_FREE_MERGE;
            if (stat.mp && stat.mn) begin
               state_in = S_SHIFT_DOWN;
            end else if (stat.mp || stat.mn || stat.seg_full || stat.seg_end) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SHIFT_UP;
            end
         end
         S_SHIFT_UP: begin
            cmd.op = DP_SHIFT_UP;
            if (!stat.up_more) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!stat.rsp_busy) begin
               cmd.op   = DP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire
